// ----- hdl/phr_pkg.sv -----
package phr_pkg;

  // Default sizes of the ring and of one readout
  localparam int RING_DEPTH_DEF = 32;
  localparam int REPORT_MAX_DEF = 16;

  // Width of the report count field on the result port
  localparam int REPORT_W = 5;

  // Transaction kinds on the command port
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // One stylus sample as it arrives and as it is kept
  typedef struct packed {
    logic signed [7:0] pen_status;
    logic signed [7:0] tool_kind;
    logic signed [7:0] tilt_x;
    logic signed [7:0] tilt_y;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [15:0]       pressure;
  } sample_t;

  // Classified command held in the queue
  typedef struct packed {
    logic    is_read;
    sample_t sample;
  } cmd_t;

  // Head of the queue as seen by the execution side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // One ring entry
  typedef struct packed {
    logic [7:0] frame;
    sample_t    sample;
  } entry_t;

endpackage

// ----- hdl/pen_sample_history_ring.sv -----
// Channel   Handshake              Fields
// command   start in, busy out     kind, pen_status, tool_kind, tilt_x_in, tilt_y_in,
//                                  pos_x_in, pos_y_in, pressure_in
// result    result_valid out       report_count, frame_number, pen_status_out,
//                                  tool_kind_out, tilt_x_out, tilt_y_out, pos_x_out,
//                                  pos_y_out, pressure_out, last_entry
//
// A transaction is taken when start is high and busy low; a two-entry queue decouples
// intake from execution, and busy rises only while that queue is full.
// A store occupies the execution side only for its pop; a readout of N entries holds it for
// the pop plus one ring read port access per entry, and an empty readout only for its pop.
// Results appear one per cycle with result_valid for exactly one cycle; they cannot be held off.
// Reset (rst, synchronous) empties the queue and clears pointer, count and frame number;
// the ring itself is not cleared, since only written entries are ever read.
module pen_sample_history_ring #(
  parameter int RING_DEPTH = phr_pkg::RING_DEPTH_DEF,
  parameter int REPORT_MAX = phr_pkg::REPORT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic signed [7:0]             pen_status,
  input  logic signed [7:0]             tool_kind,
  input  logic signed [7:0]             tilt_x_in,
  input  logic signed [7:0]             tilt_y_in,
  input  logic [15:0]                   pos_x_in,
  input  logic [15:0]                   pos_y_in,
  input  logic [15:0]                   pressure_in,
  output logic                          result_valid,
  output logic [phr_pkg::REPORT_W-1:0]  report_count,
  output logic [7:0]                    frame_number,
  output logic signed [7:0]             pen_status_out,
  output logic signed [7:0]             tool_kind_out,
  output logic signed [7:0]             tilt_x_out,
  output logic signed [7:0]             tilt_y_out,
  output logic [15:0]                   pos_x_out,
  output logic [15:0]                   pos_y_out,
  output logic [15:0]                   pressure_out,
  output logic                          last_entry
);
  import phr_pkg::*;

  sample_t   in_sample;
  sample_t   result_sample;
  cmd_slot_t head;
  logic      pop;

  // Gather the incoming sample fields
  assign in_sample = '{
    pen_status: pen_status,
    tool_kind:  tool_kind,
    tilt_x:     tilt_x_in,
    tilt_y:     tilt_y_in,
    pos_x:      pos_x_in,
    pos_y:      pos_y_in,
    pressure:   pressure_in
  };

  phr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .sample (in_sample),
    .busy   (busy),
    .head   (head),
    .pop    (pop)
  );

  phr_back #(
    .RING_DEPTH (RING_DEPTH),
    .REPORT_MAX (REPORT_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .last_entry    (last_entry),
    .report_count  (report_count),
    .frame_number  (frame_number),
    .result_sample (result_sample)
  );

  // Spread the stored sample over the result ports
  assign pen_status_out = result_sample.pen_status;
  assign tool_kind_out  = result_sample.tool_kind;
  assign tilt_x_out     = result_sample.tilt_x;
  assign tilt_y_out     = result_sample.tilt_y;
  assign pos_x_out      = result_sample.pos_x;
  assign pos_y_out      = result_sample.pos_y;
  assign pressure_out   = result_sample.pressure;

endmodule

// ----- hdl/phr_front.sv -----
module phr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                kind,
  input  phr_pkg::sample_t    sample,
  output logic                busy,
  output phr_pkg::cmd_slot_t  head,
  input  logic                pop
);
  import phr_pkg::*;

  // Two-entry queue; pointers wrap naturally, so the depth stays a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              accept;
  logic              push;

  // Take a transaction whenever the queue has room
  assign busy   = (fill == FILL_FULL);
  assign accept = start && !busy;

  // Drop store transactions that carry no pen contact
  assign push = accept && ((kind == KIND_READ) || (sample.pen_status != 8'sd0));

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{is_read: (kind == KIND_READ), sample: sample};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

  // The execution side only pops a present command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("queue popped while empty");

  // A dropped sample must never reach the queue
  a_no_empty_store: assert property (@(posedge clk) disable iff (rst)
    push && (kind == KIND_STORE) |-> sample.pen_status != 8'sd0)
    else $error("zero-status sample queued");

endmodule

// ----- hdl/phr_back.sv -----
module phr_back #(
  parameter int RING_DEPTH = phr_pkg::RING_DEPTH_DEF,
  parameter int REPORT_MAX = phr_pkg::REPORT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  phr_pkg::cmd_slot_t              head,
  output logic                            pop,
  output logic                            result_valid,
  output logic                            last_entry,
  output logic [phr_pkg::REPORT_W-1:0]    report_count,
  output logic [7:0]                      frame_number,
  output phr_pkg::sample_t                result_sample
);
  import phr_pkg::*;

  localparam int COUNT_CAP = (REPORT_MAX < RING_DEPTH) ? REPORT_MAX : RING_DEPTH;
  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(COUNT_CAP + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(COUNT_CAP);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  entry_t           ring [RING_DEPTH];
  entry_t           rdata;
  state_t           state;
  state_t           state_next;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] start_ptr;
  logic [PTR_W:0]   start_sum;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] readout_count;
  logic [7:0]       frame_counter;
  logic             zero_r;
  logic             do_store;
  logic             do_read;

  // Take the next command only between readouts
  assign pop      = (state == ST_IDLE) && head.valid;
  assign do_store = pop && !head.cmd.is_read;
  assign do_read  = pop && head.cmd.is_read;

  // Oldest entry of the readout: write pointer minus count, wrapped once
  assign start_sum = {1'b0, write_pointer} + DEPTH_EXT - (PTR_W + 1)'(stored_count);
  assign start_ptr = (start_sum >= DEPTH_EXT) ? PTR_W'(start_sum - DEPTH_EXT)
                                              : PTR_W'(start_sum);

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      ring[write_pointer] <= '{frame: frame_counter, sample: head.cmd.sample};
    end
    if (state == ST_WALK) begin
      rdata <= ring[read_pointer];
    end
  end

  // Walk the readout until the last entry has been issued
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_read && (stored_count != '0)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (remaining == CNT_ONE) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pointers, counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      stored_count  <= '0;
      remaining     <= '0;
      readout_count <= '0;
      frame_counter <= '0;
      zero_r        <= 1'b0;
      result_valid  <= 1'b0;
      last_entry    <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      last_entry   <= 1'b0;
      if (do_store) begin
        frame_counter <= frame_counter + 8'd1;
        if (stored_count != CNT_CAP) begin
          stored_count <= stored_count + 1'b1;
        end
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
      end
      if (do_read) begin
        readout_count <= stored_count;
        remaining     <= stored_count;
        read_pointer  <= start_ptr;
        zero_r        <= (stored_count == '0);
        // Empty history: one blank, final transaction
        if (stored_count == '0) begin
          result_valid <= 1'b1;
          last_entry   <= 1'b1;
        end
      end
      if (state == ST_WALK) begin
        result_valid <= 1'b1;
        last_entry   <= (remaining == CNT_ONE);
        zero_r       <= 1'b0;
        remaining    <= remaining - 1'b1;
        read_pointer <= (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
      end
    end
  end

  // Blank the entry fields on an empty readout
  assign report_count  = REPORT_W'(readout_count);
  assign frame_number  = zero_r ? 8'd0 : rdata.frame;
  assign result_sample = zero_r ? '0 : rdata.sample;

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_CAP)
    else $error("stored count beyond cap");

  a_walk_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (remaining != '0) && (remaining <= readout_count))
    else $error("walk with no entries left");

  a_blank_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_r |-> last_entry && (readout_count == '0))
    else $error("blank result not final");

endmodule
